[design/tes_pkg.sv]
// ----------------------------------------------------------------------------
// Tetrahedron element stiffness package
// Word types, widths, register codes and latencies shared by the element
// stiffness datapath, its wide multiplier and its divider lanes.
// ----------------------------------------------------------------------------
package tes_pkg;

    localparam int COORD_W    = 32;
    localparam int DIFF_W     = 33;
    localparam int MINOR_W    = 66;
    localparam int TERM_W     = 65;
    localparam int COEF_W     = 67;
    localparam int MUL_W      = 68;
    localparam int PROD_W     = 136;
    localparam int DET_W      = 101;
    localparam int ABS_W      = 99;
    localparam int DEN_W      = 102;
    localparam int LPART_W    = 64;
    localparam int LSUM_W     = 130;
    localparam int LHI_W      = 79;
    localparam int LQ_W       = 67;
    localparam int Q_W        = 32;
    localparam int LOAD_W     = 31;
    localparam int SRC_W      = 31;
    localparam int MIN_DET_W  = 63;
    localparam int CFG_DATA_W = 63;
    localparam int CFG_IDX_W  = 2;

    localparam logic [CFG_IDX_W-1:0] REG_SOURCE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_DET = 2'd1;

    localparam logic [SRC_W-1:0]     SRC_RESET     = 31'd1966080;
    localparam logic [MIN_DET_W-1:0] MIN_DET_RESET = 63'd1689;

    localparam int MUL_LAT = 3;
    localparam int DIV_LAT = 35;
    localparam int TAG_LAT = MUL_LAT + 1 + DIV_LAT;
    localparam int FE_LAST = 11;

    localparam logic [1:0] ROW_LAST = 2'd3;

    // floor(x/3) = (x * ceil(2^35/3)) >> 35 for x below 2^33
    localparam logic [33:0]      LOAD_RECIP = 34'h2_AAAA_AAAB;
    localparam logic [LHI_W-1:0] LOAD_SAT   = 79'h1_8000_0000;

    localparam logic [Q_W-1:0] Q_MAX = 32'h7FFF_FFFF;
    localparam logic [Q_W-1:0] Q_MIN = 32'h8000_0000;

    typedef logic signed [COEF_W-1:0] tes_coef_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] ax;
        logic signed [COORD_W-1:0] ay;
        logic signed [COORD_W-1:0] az;
        logic signed [COORD_W-1:0] bx;
        logic signed [COORD_W-1:0] by;
        logic signed [COORD_W-1:0] bz;
        logic signed [COORD_W-1:0] cx;
        logic signed [COORD_W-1:0] cy;
        logic signed [COORD_W-1:0] cz;
        logic signed [COORD_W-1:0] dx;
        logic signed [COORD_W-1:0] dy;
        logic signed [COORD_W-1:0] dz;
    } tes_in_t;

    typedef struct packed {
        logic [1:0]            row;
        logic signed [Q_W-1:0] k_col0;
        logic signed [Q_W-1:0] k_col1;
        logic signed [Q_W-1:0] k_col2;
        logic signed [Q_W-1:0] k_col3;
        logic [LOAD_W-1:0]     load;
        logic                  last;
    } tes_out_t;

    typedef struct packed {
        logic              valid;
        logic [1:0]        row;
        logic              last;
        logic [LOAD_W-1:0] load;
    } tes_tag_t;

    // the three other nodes of a node, ordered for a positive cofactor
    function automatic logic [1:0] tes_other(input logic [1:0] node, input logic [1:0] slot);
        logic [5:0] set;
        case (node)
            2'd0:    set = {2'd1, 2'd2, 2'd3};
            2'd1:    set = {2'd0, 2'd3, 2'd2};
            2'd2:    set = {2'd0, 2'd1, 2'd3};
            default: set = {2'd0, 2'd2, 2'd1};
        endcase
        case (slot)
            2'd0:    return set[5:4];
            2'd1:    return set[3:2];
            default: return set[1:0];
        endcase
    endfunction

endpackage

[design/tes_mul.sv]
// ----------------------------------------------------------------------------
// Wide signed multiplier
// 68 x 68 signed product over three stages: four partial products of 35-bit
// halves, two partial sums, final sum.
// ----------------------------------------------------------------------------
module tes_mul (
    input  logic                               aclk,
    input  logic                               en,
    input  logic signed [tes_pkg::MUL_W-1:0]   a,
    input  logic signed [tes_pkg::MUL_W-1:0]   b,
    output logic signed [tes_pkg::PROD_W-1:0]  prod
);

    logic signed [34:0] al, ah, bl, bh;
    logic signed [69:0] pll_reg, plh_reg, phl_reg, phh_reg;
    logic signed [tes_pkg::PROD_W-1:0] sa_reg, sb_reg, prod_reg;

    assign al = {1'b0, a[33:0]};
    assign bl = {1'b0, b[33:0]};
    assign ah = 35'(signed'(a[67:34]));
    assign bh = 35'(signed'(b[67:34]));

    always_ff @(posedge aclk) begin
        if (en) begin
            pll_reg  <= al * bl;
            plh_reg  <= al * bh;
            phl_reg  <= ah * bl;
            phh_reg  <= ah * bh;
            sa_reg   <= tes_pkg::PROD_W'(pll_reg) + (tes_pkg::PROD_W'(plh_reg) <<< 34);
            sb_reg   <= (tes_pkg::PROD_W'(phl_reg) <<< 34) + (tes_pkg::PROD_W'(phh_reg) <<< 68);
            prod_reg <= sa_reg + sb_reg;
        end
    end

    assign prod = prod_reg;

endmodule

[design/tes_div.sv]
// ----------------------------------------------------------------------------
// Stiffness divider lane
// Signed numerator over positive denominator, restoring, one quotient bit
// per stage, truncated toward zero and saturated to 32 bits.
// ----------------------------------------------------------------------------
module tes_div (
    input  logic                               aclk,
    input  logic                               en,
    input  logic signed [tes_pkg::PROD_W-1:0]  num,
    input  logic [tes_pkg::DEN_W-1:0]          den,
    output logic signed [tes_pkg::Q_W-1:0]     quo
);

    localparam int STEPS = tes_pkg::Q_W;

    logic [tes_pkg::PROD_W-1:0] mag_reg;
    logic                       sgn_reg;
    logic [tes_pkg::DEN_W-1:0]  dena_reg;

    logic [tes_pkg::DEN_W-1:0]  rem_reg [0:STEPS];
    logic [tes_pkg::Q_W-1:0]    w_reg   [0:STEPS];
    logic                       neg_reg [0:STEPS];
    logic                       ovf_reg [0:STEPS];
    logic [tes_pkg::DEN_W-1:0]  den_reg [0:STEPS];
    logic [tes_pkg::Q_W-1:0]    quo_reg;
    logic [tes_pkg::Q_W-1:0]    q_fin;

    always_ff @(posedge aclk) begin
        if (en) begin
            sgn_reg  <= num[tes_pkg::PROD_W-1];
            mag_reg  <= num[tes_pkg::PROD_W-1] ? tes_pkg::PROD_W'(-num)
                                               : tes_pkg::PROD_W'(num);
            dena_reg <= den;
            rem_reg[0] <= mag_reg[tes_pkg::DEN_W+31:32];
            w_reg[0]   <= mag_reg[31:0];
            neg_reg[0] <= sgn_reg;
            ovf_reg[0] <= mag_reg >= tes_pkg::PROD_W'({dena_reg, 32'd0});
            den_reg[0] <= dena_reg;
        end
    end

    for (genvar k = 0; k < STEPS; k++) begin : g_step
        logic [tes_pkg::DEN_W:0] t;
        logic                    ge;
        assign t  = {rem_reg[k], w_reg[k][tes_pkg::Q_W-1]};
        assign ge = t >= {1'b0, den_reg[k]};
        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[k+1] <= ge ? tes_pkg::DEN_W'(t - {1'b0, den_reg[k]})
                                   : t[tes_pkg::DEN_W-1:0];
                w_reg[k+1]   <= {w_reg[k][tes_pkg::Q_W-2:0], ge};
                neg_reg[k+1] <= neg_reg[k];
                ovf_reg[k+1] <= ovf_reg[k];
                den_reg[k+1] <= den_reg[k];
            end
        end
    end

    always_comb begin
        if (ovf_reg[STEPS]) begin
            q_fin = neg_reg[STEPS] ? tes_pkg::Q_MIN : tes_pkg::Q_MAX;
        end else if (neg_reg[STEPS]) begin
            q_fin = (w_reg[STEPS] > tes_pkg::Q_MIN) ? tes_pkg::Q_MIN : (-w_reg[STEPS]);
        end else begin
            q_fin = w_reg[STEPS][tes_pkg::Q_W-1] ? tes_pkg::Q_MAX : w_reg[STEPS];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            quo_reg <= q_fin;
        end
    end

    assign quo = signed'(quo_reg);

endmodule

[design/tet_element_stiffness_top.sv]
// ----------------------------------------------------------------------------
// Tetrahedron element stiffness
// Takes one tetrahedron word (four Q16.16 vertices) and returns four row
// words: stiffness entries (Bi.Bj + Ci.Cj + Di.Dj) / (6|det|) and the nodal
// load source*|det|/24, all truncated and saturated to Q16.16. Elements with
// |det| zero or below min_abs_det give no row. Rows issue at one row word
// per cycle while the output accepts them; the row serialiser takes the
// next element as the fourth row of the current one issues. The path from
// input to first row runs through a 12-stage element front end, three
// multiplier stages, a dot-product stage and a 35-stage divider per column.
// All stages halt together while a row word waits at the output.
// ----------------------------------------------------------------------------
module tet_element_stiffness_top (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  tes_pkg::tes_in_t                  s_data,
    output logic                              m_valid,
    input  logic                              m_ready,
    output tes_pkg::tes_out_t                 m_data,
    input  logic                              cfg_wr_en,
    input  logic [tes_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [tes_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

    localparam int FL = tes_pkg::FE_LAST;

    logic [tes_pkg::SRC_W-1:0]     src_reg;
    logic [tes_pkg::MIN_DET_W-1:0] min_det_reg;

    logic pipe_en, fe_en, ser_take;
    logic [FL:0] fv_reg;

    tes_pkg::tes_in_t in_reg;
    logic signed [tes_pkg::COORD_W-1:0] px [0:3];
    logic signed [tes_pkg::COORD_W-1:0] py [0:3];
    logic signed [tes_pkg::COORD_W-1:0] pz [0:3];

    logic signed [tes_pkg::DIFF_W-1:0]  dx_next [0:2];
    logic signed [tes_pkg::DIFF_W-1:0]  dy_next [0:2];
    logic signed [tes_pkg::DIFF_W-1:0]  dz_next [0:2];
    logic signed [tes_pkg::DIFF_W-1:0]  ey_next [0:3][0:2];
    logic signed [tes_pkg::DIFF_W-1:0]  ez_next [0:3][0:2];
    logic signed [tes_pkg::COORD_W-1:0] ay_next [0:3][0:2];
    logic signed [tes_pkg::COORD_W-1:0] ax_next [0:3][0:2];

    logic signed [tes_pkg::DIFF_W-1:0]  dx1_reg [0:2];
    logic signed [tes_pkg::DIFF_W-1:0]  dy1_reg [0:2];
    logic signed [tes_pkg::DIFF_W-1:0]  dz1_reg [0:2];
    logic signed [tes_pkg::DIFF_W-1:0]  ey1_reg [0:3][0:2];
    logic signed [tes_pkg::DIFF_W-1:0]  ez1_reg [0:3][0:2];
    logic signed [tes_pkg::COORD_W-1:0] ay1_reg [0:3][0:2];
    logic signed [tes_pkg::COORD_W-1:0] ax1_reg [0:3][0:2];

    logic signed [tes_pkg::DIFF_W-1:0]  dx2_reg [0:2];
    logic signed [tes_pkg::MINOR_W-1:0] mp_reg  [0:2];
    logic signed [tes_pkg::MINOR_W-1:0] mn_reg  [0:2];
    logic signed [tes_pkg::TERM_W-1:0]  tb_reg  [0:3][0:2];
    logic signed [tes_pkg::TERM_W-1:0]  tc_reg  [0:3][0:2];
    logic signed [tes_pkg::TERM_W-1:0]  td_reg  [0:3][0:2];

    logic signed [tes_pkg::DIFF_W-1:0]  dx3_reg [0:2];
    logic signed [tes_pkg::COEF_W-1:0]  cm_reg  [0:2];
    tes_pkg::tes_coef_t                 grad_reg [3:FL][0:3][0:2];

    logic signed [tes_pkg::PROD_W-1:0]  dp [0:2];
    logic signed [tes_pkg::PROD_W-1:0]  det_sum;
    logic signed [tes_pkg::DET_W-1:0]   det_reg;
    logic signed [tes_pkg::DET_W-1:0]   det_abs;
    logic [tes_pkg::ABS_W-1:0]          ad;
    logic                               keep_next;
    logic [tes_pkg::DEN_W-1:0]          den_next;

    logic [tes_pkg::DEN_W-1:0]          den_reg  [8:FL];
    logic                               keep_reg [8:FL];
    logic [tes_pkg::LPART_W-1:0]        lp_reg   [0:2];
    logic [tes_pkg::LSUM_W-1:0]         lsum;
    logic [tes_pkg::LHI_W-1:0]          xh_reg;
    logic                               lsat_reg;
    logic [tes_pkg::LQ_W-1:0]           lq_reg;
    logic [tes_pkg::LOAD_W-1:0]         load_reg;

    tes_pkg::tes_coef_t                 ser_g_reg [0:3][0:2];
    tes_pkg::tes_coef_t                 rp [0:2];
    logic [tes_pkg::DEN_W-1:0]          ser_den_reg;
    logic [tes_pkg::LOAD_W-1:0]         ser_load_reg;
    logic [1:0]                         ser_cnt_reg;
    logic                               ser_busy_reg;
    logic                               ser_load;

    logic signed [tes_pkg::PROD_W-1:0]  rprod [0:3][0:2];
    logic signed [tes_pkg::PROD_W-1:0]  num_reg [0:3];
    logic [tes_pkg::DEN_W-1:0]          den_dly_reg [0:tes_pkg::MUL_LAT];
    logic signed [tes_pkg::Q_W-1:0]     quo [0:3];
    tes_pkg::tes_tag_t                  tag_next;
    tes_pkg::tes_tag_t                  tag_reg [0:tes_pkg::TAG_LAT-1];

    logic                               m_valid_reg;
    tes_pkg::tes_out_t                  m_data_reg;

    // configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            src_reg     <= tes_pkg::SRC_RESET;
            min_det_reg <= tes_pkg::MIN_DET_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                tes_pkg::REG_SOURCE:  src_reg     <= cfg_wdata[tes_pkg::SRC_W-1:0];
                tes_pkg::REG_MIN_DET: min_det_reg <= cfg_wdata[tes_pkg::MIN_DET_W-1:0];
                default: ;
            endcase
        end
    end

    // flow control
    assign pipe_en  = !m_valid_reg || m_ready;
    assign ser_take = !ser_busy_reg || (ser_cnt_reg == tes_pkg::ROW_LAST);
    assign fe_en    = pipe_en && (!fv_reg[FL] || ser_take);
    assign s_ready  = fe_en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fv_reg <= '0;
        end else if (fe_en) begin
            fv_reg <= {fv_reg[FL-1:0], s_valid};
        end
    end

    // front end: differences
    always_comb begin
        px[0] = in_reg.ax; py[0] = in_reg.ay; pz[0] = in_reg.az;
        px[1] = in_reg.bx; py[1] = in_reg.by; pz[1] = in_reg.bz;
        px[2] = in_reg.cx; py[2] = in_reg.cy; pz[2] = in_reg.cz;
        px[3] = in_reg.dx; py[3] = in_reg.dy; pz[3] = in_reg.dz;
        for (int k = 0; k < 3; k++) begin
            dx_next[k] = tes_pkg::DIFF_W'(px[k+1]) - tes_pkg::DIFF_W'(px[0]);
            dy_next[k] = tes_pkg::DIFF_W'(py[k+1]) - tes_pkg::DIFF_W'(py[0]);
            dz_next[k] = tes_pkg::DIFF_W'(pz[k+1]) - tes_pkg::DIFF_W'(pz[0]);
        end
        for (int i = 0; i < 4; i++) begin
            for (int t = 0; t < 3; t++) begin
                ax_next[i][t] = px[tes_pkg::tes_other(2'(i), 2'(t))];
                ay_next[i][t] = py[tes_pkg::tes_other(2'(i), 2'(t))];
                ez_next[i][t] = tes_pkg::DIFF_W'(pz[tes_pkg::tes_other(2'(i), 2'((t + 1) % 3))])
                              - tes_pkg::DIFF_W'(pz[tes_pkg::tes_other(2'(i), 2'((t + 2) % 3))]);
                ey_next[i][t] = tes_pkg::DIFF_W'(py[tes_pkg::tes_other(2'(i), 2'((t + 1) % 3))])
                              - tes_pkg::DIFF_W'(py[tes_pkg::tes_other(2'(i), 2'((t + 2) % 3))]);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (fe_en) begin
            in_reg <= s_data;
            for (int k = 0; k < 3; k++) begin
                dx1_reg[k] <= dx_next[k];
                dy1_reg[k] <= dy_next[k];
                dz1_reg[k] <= dz_next[k];
            end
            for (int i = 0; i < 4; i++) begin
                for (int t = 0; t < 3; t++) begin
                    ax1_reg[i][t] <= ax_next[i][t];
                    ay1_reg[i][t] <= ay_next[i][t];
                    ez1_reg[i][t] <= ez_next[i][t];
                    ey1_reg[i][t] <= ey_next[i][t];
                end
            end
        end
    end

    // front end: minors and gradient terms
    always_ff @(posedge aclk) begin
        if (fe_en) begin
            for (int k = 0; k < 3; k++) begin
                dx2_reg[k] <= dx1_reg[k];
            end
            mp_reg[0] <= tes_pkg::MINOR_W'(dy1_reg[1]) * tes_pkg::MINOR_W'(dz1_reg[2]);
            mn_reg[0] <= tes_pkg::MINOR_W'(dy1_reg[2]) * tes_pkg::MINOR_W'(dz1_reg[1]);
            mp_reg[1] <= tes_pkg::MINOR_W'(dy1_reg[0]) * tes_pkg::MINOR_W'(dz1_reg[2]);
            mn_reg[1] <= tes_pkg::MINOR_W'(dy1_reg[2]) * tes_pkg::MINOR_W'(dz1_reg[0]);
            mp_reg[2] <= tes_pkg::MINOR_W'(dy1_reg[0]) * tes_pkg::MINOR_W'(dz1_reg[1]);
            mn_reg[2] <= tes_pkg::MINOR_W'(dy1_reg[1]) * tes_pkg::MINOR_W'(dz1_reg[0]);
            for (int i = 0; i < 4; i++) begin
                for (int t = 0; t < 3; t++) begin
                    tb_reg[i][t] <= tes_pkg::TERM_W'(ay1_reg[i][t])
                                  * tes_pkg::TERM_W'(ez1_reg[i][t]);
                    tc_reg[i][t] <= tes_pkg::TERM_W'(ax1_reg[i][t])
                                  * tes_pkg::TERM_W'(ez1_reg[i][t]);
                    td_reg[i][t] <= tes_pkg::TERM_W'(ax1_reg[i][t])
                                  * tes_pkg::TERM_W'(ey1_reg[i][t]);
                end
            end
        end
    end

    // front end: cofactors and gradients; middle minor negated
    always_ff @(posedge aclk) begin
        if (fe_en) begin
            for (int k = 0; k < 3; k++) begin
                dx3_reg[k] <= dx2_reg[k];
            end
            cm_reg[0] <= tes_pkg::COEF_W'(mp_reg[0]) - tes_pkg::COEF_W'(mn_reg[0]);
            cm_reg[1] <= tes_pkg::COEF_W'(mn_reg[1]) - tes_pkg::COEF_W'(mp_reg[1]);
            cm_reg[2] <= tes_pkg::COEF_W'(mp_reg[2]) - tes_pkg::COEF_W'(mn_reg[2]);
            for (int i = 0; i < 4; i++) begin
                grad_reg[3][i][0] <= tes_pkg::COEF_W'(tb_reg[i][0]) + tes_pkg::COEF_W'(tb_reg[i][1])
                                   + tes_pkg::COEF_W'(tb_reg[i][2]);
                grad_reg[3][i][1] <= tes_pkg::COEF_W'(tc_reg[i][0]) + tes_pkg::COEF_W'(tc_reg[i][1])
                                   + tes_pkg::COEF_W'(tc_reg[i][2]);
                grad_reg[3][i][2] <= tes_pkg::COEF_W'(td_reg[i][0]) + tes_pkg::COEF_W'(td_reg[i][1])
                                   + tes_pkg::COEF_W'(td_reg[i][2]);
            end
            for (int s = 4; s <= FL; s++) begin
                for (int i = 0; i < 4; i++) begin
                    for (int c = 0; c < 3; c++) begin
                        grad_reg[s][i][c] <= grad_reg[s-1][i][c];
                    end
                end
            end
        end
    end

    for (genvar k = 0; k < 3; k++) begin : g_det_mul
        tes_mul u_mul (
            .aclk (aclk),
            .en   (fe_en),
            .a    (tes_pkg::MUL_W'(dx3_reg[k])),
            .b    (tes_pkg::MUL_W'(cm_reg[k])),
            .prod (dp[k])
        );
    end

    // front end: determinant, threshold, load
    assign det_sum  = dp[0] + dp[1] + dp[2];
    assign det_abs  = det_reg[tes_pkg::DET_W-1] ? -det_reg : det_reg;
    assign ad       = det_abs[tes_pkg::ABS_W-1:0];
    assign keep_next = (ad != '0) && (ad >= tes_pkg::ABS_W'(min_det_reg));
    assign den_next = tes_pkg::DEN_W'({ad, 2'b00}) + tes_pkg::DEN_W'({ad, 1'b0});
    assign lsum     = tes_pkg::LSUM_W'(lp_reg[0])
                    + (tes_pkg::LSUM_W'(lp_reg[1]) << 33)
                    + (tes_pkg::LSUM_W'(lp_reg[2]) << 66);

    always_ff @(posedge aclk) begin
        if (fe_en) begin
            det_reg     <= det_sum[tes_pkg::DET_W-1:0];
            den_reg[8]  <= den_next;
            keep_reg[8] <= keep_next;
            for (int k = 0; k < 3; k++) begin
                lp_reg[k] <= tes_pkg::LPART_W'(ad[33*k +: 33]) * tes_pkg::LPART_W'(src_reg);
            end
            for (int s = 9; s <= FL; s++) begin
                den_reg[s]  <= den_reg[s-1];
                keep_reg[s] <= keep_reg[s-1];
            end
            xh_reg   <= lsum[tes_pkg::LSUM_W-1:51];
            lsat_reg <= xh_reg >= tes_pkg::LOAD_SAT;
            lq_reg   <= tes_pkg::LQ_W'(xh_reg[32:0]) * tes_pkg::LQ_W'(tes_pkg::LOAD_RECIP);
            load_reg <= lsat_reg ? '1 : lq_reg[65:35];
        end
    end

    // row serialiser
    assign ser_load = fe_en && fv_reg[FL] && keep_reg[FL];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ser_busy_reg <= 1'b0;
            ser_cnt_reg  <= '0;
        end else if (pipe_en) begin
            if (ser_load) begin
                ser_busy_reg <= 1'b1;
                ser_cnt_reg  <= '0;
            end else if (ser_busy_reg) begin
                ser_cnt_reg <= ser_cnt_reg + 2'd1;
                if (ser_cnt_reg == tes_pkg::ROW_LAST) begin
                    ser_busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ser_load) begin
            ser_den_reg  <= den_reg[FL];
            ser_load_reg <= load_reg;
            for (int i = 0; i < 4; i++) begin
                for (int c = 0; c < 3; c++) begin
                    ser_g_reg[i][c] <= grad_reg[FL][i][c];
                end
            end
        end
    end

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            rp[c] = ser_g_reg[ser_cnt_reg][c];
        end
        tag_next.valid = ser_busy_reg;
        tag_next.row   = ser_cnt_reg;
        tag_next.last  = ser_cnt_reg == tes_pkg::ROW_LAST;
        tag_next.load  = ser_load_reg;
    end

    // row datapath
    for (genvar j = 0; j < 4; j++) begin : g_col
        for (genvar c = 0; c < 3; c++) begin : g_comp
            tes_mul u_mul (
                .aclk (aclk),
                .en   (pipe_en),
                .a    (tes_pkg::MUL_W'(rp[c])),
                .b    (tes_pkg::MUL_W'(ser_g_reg[j][c])),
                .prod (rprod[j][c])
            );
        end

        always_ff @(posedge aclk) begin
            if (pipe_en) begin
                num_reg[j] <= rprod[j][0] + rprod[j][1] + rprod[j][2];
            end
        end

        tes_div u_div (
            .aclk (aclk),
            .en   (pipe_en),
            .num  (num_reg[j]),
            .den  (den_dly_reg[tes_pkg::MUL_LAT]),
            .quo  (quo[j])
        );
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            den_dly_reg[0] <= ser_den_reg;
            for (int s = 1; s <= tes_pkg::MUL_LAT; s++) begin
                den_dly_reg[s] <= den_dly_reg[s-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int s = 0; s < tes_pkg::TAG_LAT; s++) begin
                tag_reg[s].valid <= 1'b0;
            end
        end else if (pipe_en) begin
            tag_reg[0] <= tag_next;
            for (int s = 1; s < tes_pkg::TAG_LAT; s++) begin
                tag_reg[s] <= tag_reg[s-1];
            end
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (pipe_en) begin
            m_valid_reg <= tag_reg[tes_pkg::TAG_LAT-1].valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            m_data_reg.row    <= tag_reg[tes_pkg::TAG_LAT-1].row;
            m_data_reg.k_col0 <= quo[0];
            m_data_reg.k_col1 <= quo[1];
            m_data_reg.k_col2 <= quo[2];
            m_data_reg.k_col3 <= quo[3];
            m_data_reg.load   <= tag_reg[tes_pkg::TAG_LAT-1].load;
            m_data_reg.last   <= tag_reg[tes_pkg::TAG_LAT-1].last;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    a_last_row: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.last == (m_data.row == tes_pkg::ROW_LAST)))
        else $error("last flag out of step with row index");

    a_ser_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (ser_busy_reg && pipe_en && ser_cnt_reg != tes_pkg::ROW_LAST) |=>
        (ser_busy_reg && ser_cnt_reg == 2'($past(ser_cnt_reg) + 2'd1)))
        else $error("row serialiser skipped or repeated a row");

    a_fe_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (fv_reg[FL] && !fe_en) |=> fv_reg[FL])
        else $error("stalled element dropped from front end");

    a_ser_free: assert property (@(posedge aclk) disable iff (!aresetn)
        ser_load |-> (!ser_busy_reg || ser_cnt_reg == tes_pkg::ROW_LAST))
        else $error("element loaded over unfinished rows");

endmodule
